>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the decimal text block.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SIPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SIPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/sipd_pkg.sv
// Package for the signed integer to padded decimal text block.
// Holds payload structs, the control state type, ASCII constants and sizing helpers.
package sipd_pkg;

  // Fixed field widths of the request and the response.
  localparam int VALUE_W     = 32;
  localparam int WIDTH_W     = 6;
  localparam int CHAR_W      = 7;

  // Parameter defaults.
  localparam int DEF_MAX_FIELD_WIDTH = 63;
  localparam int DEF_VALUE_BITS      = 32;

  // ASCII codes used in the text.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]        min_width;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } sipd_state_t;

  // Number of decimal digits that cover a magnitude of the given bit count.
  function automatic int sipd_num_digits(input int bits);
    return (bits * 3) / 10 + 1;
  endfunction

endpackage

>>> rtl/core/sipd_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on sipd_pkg for the digit count helper.
module sipd_dabble #(
  parameter int VALUE_BITS = sipd_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mag,
  output logic                  done,
  output logic [sipd_pkg::sipd_num_digits(VALUE_BITS)-1:0][3:0] digits
);
  import sipd_pkg::*;

  localparam int NUM_DIGITS = sipd_num_digits(VALUE_BITS);
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]            mag_r;
  logic [NUM_DIGITS-1:0][3:0]       bcd_r;
  logic [NUM_DIGITS-1:0][3:0]       adj;
  logic [BCD_W-1:0]                 adj_flat;
  logic [BCD_W-1:0]                 bcd_nxt;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             busy_r;

  // Each digit is corrected on its own before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    adj_flat = adj;
    bcd_nxt  = {adj_flat[BCD_W-2:0], mag_r[VALUE_BITS-1]};
  end

  // Control: one step per cycle for every magnitude bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(VALUE_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath shift registers; the digits hold once the last step is done.
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  assign done   = busy_r && (cnt_r == CNT_W'(1));
  assign digits = bcd_r;

endmodule

>>> rtl/core/signed_int_to_padded_decimal_top.sv
// Signed integer to padded decimal ASCII text, top level.
// Depends on sipd_pkg, sipd_dabble and assert_macros.svh.
//
// Usage:
//   A request on in_req (value, min_width) is taken when in_valid and
//   in_ready are both high. The block handles one request at a time and
//   raises in_ready only while it has no request in work.
//   The text comes out on out_rsp one character per response, most
//   significant first: spaces up to min_width (capped at MAX_FIELD_WIDTH),
//   a minus sign for a negative value, then the digits. The final character
//   has last set.
//   Sequence: the magnitude is converted one bit per cycle in the BCD shift
//   register, the text is sized in ST_SIZE, and the characters are then
//   registered one by one in ST_EMIT. A new request is taken only once the
//   last character of the previous one has been registered.
//   A stalled receiver holds the output register, and the emission waits.
//   Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module signed_int_to_padded_decimal_top #(
  parameter int MAX_FIELD_WIDTH = sipd_pkg::DEF_MAX_FIELD_WIDTH,
  parameter int VALUE_BITS      = sipd_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sipd_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output sipd_pkg::out_rsp_t out_rsp
);
  import sipd_pkg::*;

`include "assert_macros.svh"

  localparam int NUM_DIGITS = sipd_num_digits(VALUE_BITS);
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int DIDX_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  sipd_state_t                 state_r, state_nxt;
  logic                        neg_r;
  logic [WIDTH_W-1:0]          width_r;
  logic [ND_W-1:0]             nd_r, nd_enc;
  logic [WIDTH_W-1:0]          pos_r, pos_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_rsp_t                    out_rsp_r, out_rsp_nxt;

  logic signed [VALUE_BITS-1:0] val_ext;
  logic [VALUE_BITS-1:0]        mag;
  logic                         in_neg;
  logic [WIDTH_W-1:0]           width_sat;
  logic                         in_fire;
  logic                         conv_done;
  logic [NUM_DIGITS-1:0][3:0]   digits;
  logic [3:0]                   cur_digit;
  logic [WIDTH_W-1:0]           text_len;
  logic [WIDTH_W-1:0]           total;
  logic                         out_free;

  // Request decode: sign, unsigned magnitude of VALUE_BITS bits, capped width.
  assign in_fire   = in_valid && in_ready;
  assign val_ext   = VALUE_BITS'(in_req.value);
  assign in_neg    = val_ext[VALUE_BITS-1];
  assign mag       = in_neg ? (~val_ext + 1'b1) : val_ext;
  assign width_sat = (in_req.min_width > WIDTH_W'(MAX_FIELD_WIDTH)) ?
                     WIDTH_W'(MAX_FIELD_WIDTH) : in_req.min_width;

  sipd_dabble #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .mag    (mag),
    .done   (conv_done),
    .digits (digits)
  );

  // Significant digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    nd_enc = ND_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        nd_enc = ND_W'(i + 1);
      end
    end
  end

  assign text_len = WIDTH_W'(nd_enc) + WIDTH_W'(neg_r);
  assign total    = (width_r > text_len) ? width_r : text_len;

  // Digit selected by the character position counted from the end.
  assign cur_digit = digits[pos_r[DIDX_W-1:0]];
  assign out_free  = !out_valid_r || out_ready;

  // Next state and the character to emit.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        pos_nxt   = total - 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rsp_nxt.last = (pos_r == '0);
          if (pos_r < WIDTH_W'(nd_r)) begin
            out_rsp_nxt.character = CHAR_ZERO + CHAR_W'(cur_digit);
          end else if (neg_r && (pos_r == WIDTH_W'(nd_r))) begin
            out_rsp_nxt.character = CHAR_MINUS;
          end else begin
            out_rsp_nxt.character = CHAR_SPACE;
          end
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg_r   <= in_neg;
      width_r <= width_sat;
    end
    if (state_r == ST_SIZE) begin
      nd_r <= nd_enc;
    end
    pos_r     <= pos_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A new request never starts while a non-final character is still pending.
  `SIPD_ASSERT(a_start_after_last, (in_fire && out_valid_r) |-> out_rsp_r.last,
               "request accepted before the previous text was complete")
  // The converter only finishes while the controller waits for it.
  `SIPD_ASSERT(a_done_in_conv, conv_done |-> (state_r == ST_CONV),
               "converter finished outside the conversion state")
  // Every digit emitted is a valid BCD digit.
  `SIPD_ASSERT_NEVER(a_bcd_digit, (state_r == ST_EMIT) && (pos_r < WIDTH_W'(nd_r)) &&
                     (cur_digit > 4'd9), "BCD digit out of range")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for signed_int_to_padded_decimal_top.
// Depends on sipd_pkg. Requests are checked against a predictor of the padded
// decimal text, under random idling on both sides.
module testbench;
  import sipd_pkg::*;

  localparam int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH;
  localparam int CLK_PERIOD      = 10;
  // Covers one conversion and then up to 63 characters.
  localparam int SETTLE_CYCLES   = 120;
  localparam longint TIMEOUT_CYCLES = 1000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_rsp;

  // Characters still owed by the block, oldest first.
  out_rsp_t expected_chars[$];
  int       error_count;
  int       send_idle_pct;
  int       recv_stall_pct;

  signed_int_to_padded_decimal_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Appends the text of one request to the expected characters: spaces up to
  // the field width, a minus sign for negative values, then the digits.
  function automatic void predict_padded_text(input in_req_t req);
    logic        negative;
    logic [32:0] magnitude;
    logic [3:0]  digit_buf[12];
    int          num_digits;
    int          field_w;
    int          text_len;
    int          pad;
    int          total;
    int          emitted;
    out_rsp_t    ch;
    negative   = req.value[VALUE_W-1];
    // One extra bit keeps the most negative value's magnitude intact.
    magnitude  = negative ? (33'd0 - {1'b1, req.value}) : {1'b0, req.value};
    num_digits = 0;
    do begin
      digit_buf[num_digits] = 4'(magnitude % 10);
      magnitude = magnitude / 10;
      num_digits++;
    end while (magnitude != 0);
    field_w  = (int'(req.min_width) > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH :
               int'(req.min_width);
    text_len = num_digits + (negative ? 1 : 0);
    pad      = (field_w > text_len) ? field_w - text_len : 0;
    total    = pad + text_len;
    emitted  = 0;
    for (int i = 0; i < pad; i++) begin
      emitted++;
      ch.character = CHAR_SPACE;
      ch.last      = (emitted == total);
      expected_chars.push_back(ch);
    end
    if (negative) begin
      emitted++;
      ch.character = CHAR_MINUS;
      ch.last      = (emitted == total);
      expected_chars.push_back(ch);
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      emitted++;
      ch.character = CHAR_ZERO + digit_buf[i];
      ch.last      = (emitted == total);
      expected_chars.push_back(ch);
    end
  endfunction

  // Sends one request, idling first at random, and records its text once taken.
  task automatic send_request(input logic signed [VALUE_W-1:0] value,
                              input logic [WIDTH_W-1:0] min_width);
    in_req_t req;
    req.value     = value;
    req.min_width = min_width;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_padded_text(req);
  endtask

  // Holds off new requests until every owed character has come out.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver side: stall at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each taken character with the oldest one owed.
  always @(posedge clk) begin
    out_rsp_t exp_ch;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_rsp.character, out_rsp.last));
      end else begin
        exp_ch = expected_chars.pop_front();
        if (out_rsp.character !== exp_ch.character)
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_rsp.character, exp_ch.character));
        if (out_rsp.last !== exp_ch.last)
          report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
                                    out_rsp.last, exp_ch.last, exp_ch.character));
      end
    end
  end

  // Zero and single digits of both signs, with and without padding.
  task automatic test_zero_and_sign();
    send_request(32'sd0, 6'd0);
    send_request(32'sd0, 6'd63);
    send_request(32'sd1, 6'd0);
    send_request(-32'sd1, 6'd0);
    send_request(32'sd9, 6'd1);
    send_request(-32'sd7, 6'd63);
  endtask

  // Largest magnitudes, including the most negative value.
  task automatic test_extreme_magnitudes();
    send_request(32'sh7FFFFFFF, 6'd0);
    send_request(32'sh80000000, 6'd0);
    send_request(32'sh80000000, 6'd12);
    send_request(32'sh80000001, 6'd63);
    send_request(32'sd10, 6'd2);
    send_request(-32'sd10, 6'd3);
  endtask

  // Field width below, equal to and above the text length.
  task automatic test_field_widths();
    send_request(-32'sd123, 6'd3);
    send_request(-32'sd123, 6'd4);
    send_request(-32'sd123, 6'd5);
    send_request(32'sh7FFFFFFF, 6'd10);
    send_request(32'sh80000000, 6'd11);
    send_request(32'sd99999, 6'd63);
    send_request(32'sd42, 6'd32);
  endtask

  // Random requests under the given idling on each side.
  task automatic test_random_stream(input int count, input int idle_pct,
                                    input int stall_pct);
    logic signed [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]        min_width;
    longint                    pow10;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = $urandom;
        4, 5: value = $urandom_range(0, 1998) - 999;
        6, 7: begin
          // Power of ten boundaries, where the digit count changes.
          pow10 = 1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
          pow10 = pow10 - $urandom_range(0, 1);
          value = $urandom_range(0, 1) ? VALUE_W'(-pow10) : VALUE_W'(pow10);
        end
        8: value = $urandom_range(0, 1) ? 32'sh80000000 + $urandom_range(0, 5)
                                        : 32'sh7FFFFFFF - $urandom_range(0, 5);
        default: begin
          value = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) value = -value;
        end
      endcase
      case ($urandom_range(0, 3))
        0, 1: min_width = WIDTH_W'($urandom_range(0, 63));
        2: min_width = WIDTH_W'($urandom_range(0, 12));
        default: min_width = WIDTH_W'($urandom_range(0, 15));
      endcase
      send_request(value, min_width);
    end
  endtask

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    out_ready      = 1'b0;
    error_count    = 0;
    send_idle_pct  = 30;
    recv_stall_pct = 53;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_and_sign();
    test_extreme_magnitudes();
    test_field_widths();
    drain_outputs();
    test_random_stream(130, 30, 53);
    drain_outputs();
    test_random_stream(130, 53, 30);
    test_random_stream(120, 0, 0);
    drain_outputs();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
